// File: hdl/pbc_pkg.sv
// ============================================================================
// pbc_pkg: shared types and constants of the proximity beep cadence unit
// Field widths, register bank layout, queue entry format, sequencer and
// phase codes, and the volume to duty scaling function.
// ============================================================================
package pbc_pkg;

    // Input item layout
    localparam int DIST_W       = 10;
    localparam int DIST_FIELDS  = 4;
    localparam int SENSOR_COUNT = 4;
    localparam int USED_SENSORS = (SENSOR_COUNT < DIST_FIELDS) ? SENSOR_COUNT : DIST_FIELDS;
    localparam int DIST_MAX     = 999;
    localparam int MUTED_BIT    = DIST_FIELDS * DIST_W;
    localparam int ACTIVE_BIT   = MUTED_BIT + 1;
    localparam int S_TDATA_W    = 48;

    // Result item layout
    localparam int DUTY_W    = 8;
    localparam int TONE_W    = 15;
    localparam int M_TDATA_W = 24;

    // Register bank
    localparam int VOL_W       = 7;
    localparam int BPM_W       = 10;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    localparam logic [VOL_W-1:0]  VOL_FULL       = VOL_W'(100);
    localparam logic [VOL_W-1:0]  VOL_RESET      = VOL_W'(100);
    localparam logic [TONE_W-1:0] TONE_RESET     = TONE_W'(1760);
    localparam logic [DIST_W-1:0] RED_RESET      = DIST_W'(50);
    localparam logic [DIST_W-1:0] YELLOW_RESET   = DIST_W'(200);
    localparam logic [BPM_W-1:0]  SLOWEST_RESET  = BPM_W'(0);
    localparam logic [BPM_W-1:0]  FASTEST_RESET  = BPM_W'(300);

    // Timing (milliseconds)
    localparam int COUNT_W      = 16;
    localparam int WAIT_MS      = 100;
    localparam int RED_MS       = 1000;
    localparam int BEEP_MS      = 100;
    localparam int MS_PER_MIN   = 60000;
    localparam int GAP_ZERO_BPM = 500;

    // Serial divider
    localparam int DIVIDEND_W = 20;
    localparam int DIVISOR_W  = 10;

    // Request queue
    localparam int QUEUE_DEPTH_DEF = 2;

    // Duty scaling: vol*128/100, division by 100 done as multiply by 5243 >> 19
    localparam int DUTY_SCALE_SHIFT = 7;
    localparam int SCALED_W         = VOL_W + DUTY_SCALE_SHIFT;
    localparam int PCT_RECIP        = 5243;
    localparam int PCT_RECIP_W      = 13;
    localparam int PCT_SHIFT        = 19;
    localparam int PCT_PROD_W       = SCALED_W + PCT_RECIP_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VOLUME  = 3'd0,
        CFG_TONE    = 3'd1,
        CFG_RED     = 3'd2,
        CFG_YELLOW  = 3'd3,
        CFG_SLOWEST = 3'd4,
        CFG_FASTEST = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [VOL_W-1:0]  volume;
        logic [TONE_W-1:0] tone;
        logic [DIST_W-1:0] red;
        logic [DIST_W-1:0] yellow;
        logic [BPM_W-1:0]  slowest;
        logic [BPM_W-1:0]  fastest;
    } cfg_t;

    // Class of a tick as seen by the front end
    typedef enum logic [1:0] {
        KIND_INACTIVE = 2'd0,
        KIND_SILENT   = 2'd1,
        KIND_RED      = 2'd2,
        KIND_CADENCE  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [DIST_W-1:0] offset;   // yellow - min distance
    } q_entry_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_BEEP = 2'd2,
        PH_GAP  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        BK_READY   = 2'd0,
        BK_DIV_BPM = 2'd1,
        BK_DIV_GAP = 2'd2
    } back_state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [DUTY_W-1:0] duty_of(input logic [VOL_W-1:0] vol);
        logic [VOL_W-1:0]      v;
        logic [SCALED_W-1:0]   scaled;
        logic [PCT_PROD_W-1:0] prod;
        v      = (vol > VOL_FULL) ? VOL_FULL : vol;
        scaled = {v, {DUTY_SCALE_SHIFT{1'b0}}};
        prod   = PCT_PROD_W'(scaled) * PCT_PROD_W'(PCT_RECIP);
        return prod[PCT_SHIFT+DUTY_W-1:PCT_SHIFT];
    endfunction

endpackage

// File: hdl/pbc_front.sv
// ============================================================================
// pbc_front: tick intake and classification
// Takes the minimum of the used sensor distances and sorts the tick into
// inactive, silent, red zone or cadence band before it enters the queue.
// ============================================================================
module pbc_front import pbc_pkg::*; (
    input  cfg_t                 cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 q_push,
    output q_entry_t             q_wdata,
    input  logic                 q_full
);

    logic [DIST_W-1:0] dist_min;
    logic [DIST_W-1:0] dist_cur;
    logic              muted;
    logic              active;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign muted    = s_tdata[MUTED_BIT];
    assign active   = s_tdata[ACTIVE_BIT];

    // Minimum distance, each sensor capped at the range limit
    always_comb begin
        dist_min = DIST_W'(DIST_MAX);
        dist_cur = '0;
        for (int i = 0; i < USED_SENSORS; i++) begin
            dist_cur = s_tdata[i*DIST_W +: DIST_W];
            if (dist_cur > DIST_W'(DIST_MAX)) begin
                dist_cur = DIST_W'(DIST_MAX);
            end
            if (dist_cur < dist_min) begin
                dist_min = dist_cur;
            end
        end
    end

    // Classification
    always_comb begin
        q_wdata.offset = cfg.yellow - dist_min;
        priority if (!active) begin
            q_wdata.kind = KIND_INACTIVE;
        end else if (muted || dist_min > cfg.yellow) begin
            q_wdata.kind = KIND_SILENT;
        end else if (dist_min <= cfg.red) begin
            q_wdata.kind = KIND_RED;
        end else begin
            q_wdata.kind = KIND_CADENCE;
        end
    end

endmodule

// File: hdl/pbc_queue.sv
// ============================================================================
// pbc_queue: short request queue between front and back end
// Register based FIFO; lets the front keep taking ticks while the back end
// runs its divisions.
// ============================================================================
module pbc_queue import pbc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t wdata,
    output logic     full,
    input  logic     pop,
    output q_entry_t rdata,
    output logic     valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;

    assign full  = (fill_reg == CNT_W'(DEPTH));
    assign valid = (fill_reg != '0);
    assign rdata = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: hdl/pbc_divider.sv
// ============================================================================
// pbc_divider: serial restoring divider
// One quotient bit per cycle; a run yields DIVIDEND_W quotient bits after start.
// The quotient holds until the next start. Divisor must be nonzero.
// ============================================================================
module pbc_divider import pbc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    assign trial = {rem_reg, quot_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    // One shift-subtract step per cycle
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next  = diff[DIVISOR_W-1:0];
                quot_next = {quot_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[DIVISOR_W-1:0];
                quot_next = {quot_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quot_reg;

endmodule

// File: hdl/pbc_back.sv
// ============================================================================
// pbc_back: cadence sequencer
// Pops classified ticks, advances phase and countdown, drives the shared
// divider for beat rate and gap length, and holds the result register.
// ============================================================================
module pbc_back import pbc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 q_valid,
    input  q_entry_t             q_rdata,
    output logic                 q_pop,
    output div_req_t             div_req,
    input  div_rsp_t             div_rsp,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    back_state_t         state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  pending_reg, pending_next;
    logic [DUTY_W-1:0]   duty_reg, duty_next;
    logic [TONE_W-1:0]   tone_reg, tone_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_buzz_reg, out_buzz_next;
    logic [DUTY_W-1:0]   out_duty_reg, out_duty_next;
    logic [TONE_W-1:0]   out_tone_reg, out_tone_next;

    logic                out_free;
    logic                take;
    logic                decision;
    logic                to_gap;
    logic                start_cadence;
    logic                div_done;
    logic                emit;
    logic                span_neg;
    logic [BPM_W-1:0]    span;
    logic [BPM_W-1:0]    bpm;
    logic [COUNT_W-1:0]  gap_ms;

    assign out_free      = !out_valid_reg || m_tready;
    assign take          = (state_reg == BK_READY) && q_valid && out_free;
    assign decision      = (phase_reg == PH_IDLE) || (count_reg == '0);
    assign to_gap        = (phase_reg == PH_BEEP) && (pending_reg != '0);
    assign start_cadence = take && (q_rdata.kind == KIND_CADENCE) && decision && !to_gap;
    assign div_done      = !div_rsp.busy;

    // Beat rate from the first quotient, clamped to the configured band
    assign span_neg = cfg.fastest < cfg.slowest;
    assign span     = span_neg ? (cfg.slowest - cfg.fastest) : (cfg.fastest - cfg.slowest);

    always_comb begin
        if (span_neg) begin
            bpm = (div_rsp.quotient != '0) ? cfg.slowest : cfg.fastest;
        end else if (div_rsp.quotient > DIVIDEND_W'(span)) begin
            bpm = cfg.fastest;
        end else begin
            bpm = cfg.slowest + div_rsp.quotient[BPM_W-1:0];
        end
    end

    // Gap from the second quotient, floored at zero
    assign gap_ms = (div_rsp.quotient > DIVIDEND_W'(BEEP_MS)) ?
                    COUNT_W'(div_rsp.quotient - DIVIDEND_W'(BEEP_MS)) : '0;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_READY: begin
                if (start_cadence) begin
                    state_next = BK_DIV_BPM;
                end
            end
            BK_DIV_BPM: begin
                if (div_done) begin
                    if (bpm != '0) begin
                        state_next = BK_DIV_GAP;
                    end else if (out_free) begin
                        state_next = BK_READY;
                    end
                end
            end
            BK_DIV_GAP: begin
                if (div_done && out_free) begin
                    state_next = BK_READY;
                end
            end
            default: state_next = BK_READY;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        phase_next       = phase_reg;
        count_next       = count_reg;
        pending_next     = pending_reg;
        duty_next        = duty_reg;
        tone_next        = tone_reg;
        q_pop            = 1'b0;
        emit             = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            BK_READY: begin
                if (take) begin
                    q_pop = 1'b1;
                    emit  = 1'b1;
                    priority if (q_rdata.kind == KIND_INACTIVE) begin
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end else if (!decision) begin
                        count_next = count_reg - 1'b1;
                    end else if (to_gap) begin
                        phase_next = PH_GAP;
                        count_next = pending_reg - 1'b1;
                    end else begin
                        unique case (q_rdata.kind)
                            KIND_SILENT: begin
                                phase_next = PH_WAIT;
                                count_next = COUNT_W'(WAIT_MS - 1);
                            end
                            KIND_RED: begin
                                phase_next   = PH_BEEP;
                                count_next   = COUNT_W'(RED_MS - 1);
                                pending_next = '0;
                                duty_next    = duty_of(cfg.volume);
                                tone_next    = cfg.tone;
                            end
                            KIND_CADENCE: begin
                                // result comes once the gap is known, or once the beat rate comes out as zero
                                emit             = 1'b0;
                                div_req.start    = 1'b1;
                                div_req.dividend = DIVIDEND_W'(q_rdata.offset) *
                                                   DIVIDEND_W'(span);
                                div_req.divisor  = cfg.yellow - cfg.red;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            BK_DIV_BPM: begin
                if (div_done) begin
                    if (bpm != '0) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIVIDEND_W'(MS_PER_MIN);
                        div_req.divisor  = bpm;
                    end else if (out_free) begin
                        emit         = 1'b1;
                        phase_next   = PH_BEEP;
                        count_next   = COUNT_W'(BEEP_MS - 1);
                        pending_next = COUNT_W'(GAP_ZERO_BPM);
                        duty_next    = duty_of(cfg.volume);
                        tone_next    = cfg.tone;
                    end
                end
            end
            BK_DIV_GAP: begin
                if (div_done && out_free) begin
                    emit         = 1'b1;
                    phase_next   = PH_BEEP;
                    count_next   = COUNT_W'(BEEP_MS - 1);
                    pending_next = gap_ms;
                    duty_next    = duty_of(cfg.volume);
                    tone_next    = cfg.tone;
                end
            end
            default: ;
        endcase
    end

    // Result register
    always_comb begin
        out_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_buzz_next  = out_buzz_reg;
        out_duty_next  = out_duty_reg;
        out_tone_next  = out_tone_reg;
        if (emit) begin
            out_buzz_next = (phase_next == PH_BEEP);
            out_duty_next = (phase_next == PH_BEEP) ? duty_next : '0;
            out_tone_next = tone_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_READY;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            pending_reg   <= '0;
            duty_reg      <= '0;
            tone_reg      <= TONE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            duty_reg      <= duty_next;
            tone_reg      <= tone_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_buzz_reg <= out_buzz_next;
        out_duty_reg <= out_duty_next;
        out_tone_reg <= out_tone_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_tone_reg, out_duty_reg, out_buzz_reg};

    // A gap is only entered with a nonzero pending length
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_GAP |-> pending_reg != '0)
        else $error("gap phase with zero pending gap");

    // The divider is never restarted mid-run
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // Requests leave the queue only when the sequencer can take them
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == BK_READY && q_valid)
        else $error("queue popped outside ready state");

    // A waiting result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> !out_valid_reg || m_tready)
        else $error("result register overwritten");

endmodule

// File: hdl/proximity_beep_cadence_unit.sv
// ============================================================================
// proximity_beep_cadence_unit: parking aid buzzer cadence generator
// One request per millisecond tick; one result per request giving buzzer
// state, PWM duty and tone. Holds the register bank and joins the front
// end, request queue, sequencer and shared divider.
//
//   channel  | direction | payload
//   s_*      | in        | four distances, muted, assist_active
//   m_*      | out       | buzzer_on, duty_level, tone_hz
//   cfg_*    | in        | register index, write data
//
// Most ticks: the queue takes the tick at the accepting edge, then the
// sequencer pops it and loads the result register.
// A tick that starts a cadence-band beep gives its result after two runs
// of the serial divider (beat rate, then gap) plus handoffs, or after one
// run when the beat rate comes out as zero.
// Reset is synchronous, active low; no clearing pass is needed.
// A full queue drops s_tready; a result not yet taken holds the sequencer
// from popping the next request and from emitting.
// ============================================================================
module proximity_beep_cadence_unit import pbc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // request channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // distance_a, distance_b, distance_c, distance_d, muted, assist_active, pad
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // buzzer_on, duty_level, tone_hz
    output logic [M_TDATA_W-1:0]   m_tdata,
    // register write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t     cfg_reg, cfg_next;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_valid;
    q_entry_t q_wdata;
    q_entry_t q_rdata;
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign cfg_ready = 1'b1;

    // Register bank writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_VOLUME:  cfg_next.volume  = cfg_data[VOL_W-1:0];
                CFG_TONE:    cfg_next.tone    = cfg_data[TONE_W-1:0];
                CFG_RED:     cfg_next.red     = cfg_data[DIST_W-1:0];
                CFG_YELLOW:  cfg_next.yellow  = cfg_data[DIST_W-1:0];
                CFG_SLOWEST: cfg_next.slowest = cfg_data[BPM_W-1:0];
                CFG_FASTEST: cfg_next.fastest = cfg_data[BPM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.volume  <= VOL_RESET;
            cfg_reg.tone    <= TONE_RESET;
            cfg_reg.red     <= RED_RESET;
            cfg_reg.yellow  <= YELLOW_RESET;
            cfg_reg.slowest <= SLOWEST_RESET;
            cfg_reg.fastest <= FASTEST_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pbc_front u_front (
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_push   (q_push),
        .q_wdata  (q_wdata),
        .q_full   (q_full)
    );

    pbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .valid   (q_valid)
    );

    pbc_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    pbc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
